/* hdl/ntt_pkg.sv */
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types, constants and twiddle tables of the modulo-P radix-2 NTT.
// ----------------------------------------------------------------------------
package ntt_pkg;

  // Modulus, generator and Barrett constant
  localparam logic [29:0] MOD_P  = 30'd998244353;
  localparam logic [29:0] GEN_G  = 30'd3;
  localparam logic [30:0] MU     = 31'((64'd1 << 60) / 64'(MOD_P));
  localparam logic [29:0] INV2   = 30'((32'(MOD_P) + 32'd1) >> 1);

  // Twiddle tables cover every length the modulus supports
  localparam int TBL_N   = 24;
  localparam int TIDX_W  = 5;
  localparam int MUL_LAT = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 2'd1;
  localparam logic [CFG_DATA_W-1:0] LOG_LENGTH_RST  = 4'd10;

  // Request command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [29:0] coeff_in;
    logic        final_load;
  } in_req_t;

  typedef struct packed {
    logic [29:0] coeff_out;
    logic        final_out;
  } out_rsp_t;

  // Buffer write data source
  typedef enum logic [2:0] {
    WSEL_LOAD = 3'd0,
    WSEL_ZERO = 3'd1,
    WSEL_A    = 3'd2,
    WSEL_B    = 3'd3,
    WSEL_SUM  = 3'd4,
    WSEL_DIFF = 3'd5,
    WSEL_MUL  = 3'd6
  } wsel_e;

  // Multiplier operand pairs
  typedef enum logic [1:0] {
    MOP_WV    = 2'd0,
    MOP_WSTEP = 2'd1,
    MOP_SCALE = 2'd2
  } mop_e;

  typedef struct packed {
    logic              we;
    wsel_e             wsel;
    logic              cap_a;
    logic              cap_b;
    logic              mul_start;
    mop_e              mop;
    logic              w_one;
    logic              w_load;
    logic              out_load;
    logic              out_last;
    logic [TIDX_W-1:0] tw_idx;
    logic [TIDX_W-1:0] sc_idx;
    logic              inv;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_busy;
  } dp_status_t;

  // Elaboration-time modular arithmetic for the tables
  function automatic logic [29:0] mul_c(input logic [29:0] a, input logic [29:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 30'(p % 64'(MOD_P));
  endfunction

  function automatic logic [29:0] pow_c(input logic [29:0] base, input logic [31:0] ex);
    logic [29:0] r;
    logic [29:0] b;
    r = 30'd1;
    b = base;
    for (int k = 0; k < 32; k++) begin
      if (ex[k]) r = mul_c(r, b);
      b = mul_c(b, b);
    end
    return r;
  endfunction

  // Root of unity of order 2^s
  function automatic logic [TBL_N-1:0][29:0] build_fwd();
    logic [TBL_N-1:0][29:0] t;
    for (int s = 0; s < TBL_N; s++) begin
      t[s] = pow_c(GEN_G, 32'(MOD_P - 30'd1) >> s);
    end
    return t;
  endfunction

  // Inverse root of order 2^s
  function automatic logic [TBL_N-1:0][29:0] build_inv();
    logic [TBL_N-1:0][29:0] t;
    for (int s = 0; s < TBL_N; s++) begin
      t[s] = pow_c(GEN_G, 32'(MOD_P - 30'd1) - (32'(MOD_P - 30'd1) >> s));
    end
    return t;
  endfunction

  // 2^-s mod P
  function automatic logic [TBL_N-1:0][29:0] build_scale();
    logic [TBL_N-1:0][29:0] t;
    for (int s = 0; s < TBL_N; s++) begin
      t[s] = pow_c(INV2, 32'(s));
    end
    return t;
  endfunction

  localparam logic [TBL_N-1:0][29:0] FWD_STEP = build_fwd();
  localparam logic [TBL_N-1:0][29:0] INV_STEP = build_inv();
  localparam logic [TBL_N-1:0][29:0] INV_LEN  = build_scale();

endpackage

/* hdl/ntt_mulmod.sv */
// ----------------------------------------------------------------------------
// ntt_mulmod
// Pipelined Barrett modular multiplier, a * b mod P.
// ----------------------------------------------------------------------------
module ntt_mulmod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [29:0] a_i,
  input  logic [29:0] b_i,
  output logic        done_o,
  output logic [29:0] res_o
);
  import ntt_pkg::*;

  logic [ntt_pkg::MUL_LAT-1:0] vld_q, vld_d;
  logic [59:0] p1_q, p1_d;
  logic [61:0] qm_q, qm_d;
  logic [31:0] x2_q, x3_q;
  logic [60:0] qp_full;
  logic [31:0] qp_q;
  logic [31:0] r_q, r_d;
  logic [29:0] res_q, res_d;

  // Stage math
  assign p1_d    = 60'(a_i) * 60'(b_i);
  assign qm_d    = 62'(p1_q[59:29]) * 62'(MU);
  assign qp_full = 61'(qm_q[61:31]) * 61'(MOD_P);
  assign r_d     = x3_q - qp_q;

  // Final correction, remainder below 3P
  always_comb begin
    if (r_q >= (32'(MOD_P) << 1)) begin
      res_d = 30'(r_q - (32'(MOD_P) << 1));
    end else if (r_q >= 32'(MOD_P)) begin
      res_d = 30'(r_q - 32'(MOD_P));
    end else begin
      res_d = r_q[29:0];
    end
  end

  assign vld_d = {vld_q[MUL_LAT-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Data pipeline
  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    qm_q  <= qm_d;
    x2_q  <= p1_q[31:0];
    qp_q  <= qp_full[31:0];
    x3_q  <= x2_q;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign done_o = vld_q[MUL_LAT-1];
  assign res_o  = res_q;

endmodule

/* hdl/ntt_datapath.sv */
// ----------------------------------------------------------------------------
// ntt_datapath
// Coefficient buffer, butterfly operand registers, multiplier and result reg.
// ----------------------------------------------------------------------------
module ntt_datapath #(
  parameter int LOG_MAX = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ntt_pkg::dp_cmd_t     cmd_i,
  input  logic [LOG_MAX-1:0]   raddr_i,
  input  logic [LOG_MAX-1:0]   waddr_i,
  input  logic [29:0]          load_val_i,
  output ntt_pkg::dp_status_t  status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ntt_pkg::out_rsp_t    out_rsp_o
);
  import ntt_pkg::*;

  localparam int DEPTH = 1 << LOG_MAX;

  logic [29:0] mem_q [DEPTH];
  logic [29:0] rd_data_q;
  logic [29:0] a_q, b_q, t_q, w_q;
  logic [29:0] load_red, sum_mod, diff_mod, wdata;
  logic [30:0] sum_raw;
  logic [29:0] step, scale, mul_a, mul_b, mul_res;
  logic        mul_done;
  out_rsp_t    out_q;
  logic        out_valid_q, out_valid_d;

  // Input residue reduction
  assign load_red = (load_val_i >= MOD_P) ? (load_val_i - MOD_P) : load_val_i;

  // Butterfly add and subtract mod P
  assign sum_raw  = {1'b0, a_q} + {1'b0, t_q};
  assign sum_mod  = (sum_raw >= 31'(MOD_P)) ? 30'(sum_raw - 31'(MOD_P)) : sum_raw[29:0];
  assign diff_mod = (a_q >= t_q) ? (a_q - t_q) : 30'(31'(a_q) + 31'(MOD_P) - 31'(t_q));

  always_comb begin
    case (cmd_i.wsel)
      WSEL_LOAD: wdata = load_red;
      WSEL_ZERO: wdata = '0;
      WSEL_A:    wdata = a_q;
      WSEL_B:    wdata = b_q;
      WSEL_SUM:  wdata = sum_mod;
      WSEL_DIFF: wdata = diff_mod;
      WSEL_MUL:  wdata = t_q;
      default:   wdata = '0;
    endcase
  end

  // Twiddle step and length scale lookup
  assign step  = cmd_i.inv ? INV_STEP[cmd_i.tw_idx] : FWD_STEP[cmd_i.tw_idx];
  assign scale = INV_LEN[cmd_i.sc_idx];

  always_comb begin
    case (cmd_i.mop)
      MOP_WV:    begin mul_a = w_q; mul_b = b_q;   end
      MOP_WSTEP: begin mul_a = w_q; mul_b = step;  end
      MOP_SCALE: begin mul_a = b_q; mul_b = scale; end
      default:   begin mul_a = w_q; mul_b = b_q;   end
    endcase
  end

  ntt_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // Coefficient buffer, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    rd_data_q <= mem_q[raddr_i];
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) a_q <= rd_data_q;
    if (cmd_i.cap_b) b_q <= rd_data_q;
    if (mul_done)    t_q <= mul_res;
    if (cmd_i.w_one) begin
      w_q <= 30'd1;
    end else if (cmd_i.w_load) begin
      w_q <= mul_res;
    end
    if (cmd_i.out_load) begin
      out_q.coeff_out <= rd_data_q;
      out_q.final_out <= cmd_i.out_last;
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.mul_done = mul_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_rsp_o         = out_q;

endmodule

/* hdl/ntt_ctrl.sv */
// ----------------------------------------------------------------------------
// ntt_ctrl
// Sequencer: load, zero fill, bit reversal, butterfly stages, scaling, reads.
// ----------------------------------------------------------------------------
module ntt_ctrl #(
  parameter int LOG_MAX = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ntt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ntt_pkg::in_req_t                  in_req_i,
  output ntt_pkg::dp_cmd_t                  cmd_o,
  output logic [LOG_MAX-1:0]                raddr_o,
  output logic [LOG_MAX-1:0]                waddr_o,
  input  ntt_pkg::dp_status_t               status_i
);
  import ntt_pkg::*;

  localparam int AW = LOG_MAX;
  localparam int LW = $clog2(LOG_MAX + 1);

  typedef enum logic [21:0] {
    ST_LOAD    = 22'h000001,
    ST_ZFILL   = 22'h000002,
    ST_REV     = 22'h000004,
    ST_REV_A   = 22'h000008,
    ST_REV_B   = 22'h000010,
    ST_REV_W1  = 22'h000020,
    ST_REV_W2  = 22'h000040,
    ST_BF_RD   = 22'h000080,
    ST_BF_RD2  = 22'h000100,
    ST_BF_MUL  = 22'h000200,
    ST_BF_WAIT = 22'h000400,
    ST_BF_W1   = 22'h000800,
    ST_BF_W2   = 22'h001000,
    ST_TW_MUL  = 22'h002000,
    ST_TW_WAIT = 22'h004000,
    ST_SC_RD   = 22'h008000,
    ST_SC_CAP  = 22'h010000,
    ST_SC_MUL  = 22'h020000,
    ST_SC_WAIT = 22'h040000,
    ST_SC_WR   = 22'h080000,
    ST_READ    = 22'h100000,
    ST_RD_OUT  = 22'h200000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] log_len_q;
  logic                  inv_mode_q;
  logic [AW:0]           load_idx_q, load_idx_d, ld_next;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic [LW-1:0]         lg_q, lg_d, eff_lg;
  logic                  inv_q, inv_d;
  logic [AW:0]           i_q, i_d;
  logic [LW-1:0]         s_q, s_d;
  logic [AW-1:0]         j_q, j_d, g_q, g_d;
  logic [AW:0]           n_act, n_cur, len;
  logic [AW-1:0]         half, lo, hi, rev_j, last_idx;
  logic                  last_i, last_grp, last_j, rev_swap;

  function automatic logic [AW-1:0] rev_bits(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int k = 0; k < AW; k++) begin
      r[k] = v[AW-1-k];
    end
    return r;
  endfunction

  // Effective length from the register, clamped to 1..LOG_MAX
  always_comb begin
    if (log_len_q == '0) begin
      eff_lg = LW'(1);
    end else if (32'(log_len_q) > LOG_MAX) begin
      eff_lg = LW'(LOG_MAX);
    end else begin
      eff_lg = LW'(log_len_q);
    end
  end

  // Index arithmetic
  assign n_cur    = (AW+1)'(1) << eff_lg;
  assign n_act    = (AW+1)'(1) << lg_q;
  assign last_idx = AW'(n_act - (AW+1)'(1));
  assign last_i   = (i_q[AW-1:0] == last_idx);
  assign rev_j    = rev_bits(i_q[AW-1:0]) >> (LW'(AW) - lg_q);
  assign rev_swap = (i_q[AW-1:0] < rev_j);
  assign half     = AW'(1) << (s_q - LW'(1));
  assign len      = (AW+1)'(half) << 1;
  assign lo       = g_q + j_q;
  assign hi       = lo + half;
  assign last_grp = (((AW+1)'(g_q) + len) == n_act);
  assign last_j   = (j_q == (half - AW'(1)));

  always_comb begin
    state_d    = state_q;
    load_idx_d = load_idx_q;
    rd_idx_d   = rd_idx_q;
    lg_d       = lg_q;
    inv_d      = inv_q;
    i_d        = i_q;
    s_d        = s_q;
    j_d        = j_q;
    g_d        = g_q;
    ld_next    = load_idx_q;
    in_ready_o = 1'b0;
    raddr_o    = i_q[AW-1:0];
    waddr_o    = i_q[AW-1:0];
    cmd_o        = '0;
    cmd_o.tw_idx = TIDX_W'(s_q);
    cmd_o.sc_idx = TIDX_W'(lg_q);
    cmd_o.inv    = inv_q;

    case (state_q)
      // Coefficient load; read requests are dropped
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_req_i.cmd == CMD_LOAD)) begin
          if (load_idx_q < n_cur) begin
            cmd_o.we   = 1'b1;
            cmd_o.wsel = WSEL_LOAD;
            waddr_o    = load_idx_q[AW-1:0];
            ld_next    = load_idx_q + (AW+1)'(1);
          end
          load_idx_d = ld_next;
          if (in_req_i.final_load) begin
            lg_d       = eff_lg;
            inv_d      = inv_mode_q;
            i_d        = ld_next;
            load_idx_d = '0;
            state_d    = ST_ZFILL;
          end
        end
      end

      // Zero the positions that were not loaded
      ST_ZFILL: begin
        if (i_q < n_act) begin
          cmd_o.we   = 1'b1;
          cmd_o.wsel = WSEL_ZERO;
          i_d        = i_q + (AW+1)'(1);
        end else begin
          i_d     = '0;
          state_d = ST_REV;
        end
      end

      // Bit-reversal permutation
      ST_REV: begin
        if (rev_swap) begin
          state_d = ST_REV_A;
        end else if (last_i) begin
          s_d         = LW'(1);
          j_d         = '0;
          g_d         = '0;
          cmd_o.w_one = 1'b1;
          state_d     = ST_BF_RD;
        end else begin
          i_d = i_q + (AW+1)'(1);
        end
      end
      ST_REV_A: begin
        raddr_o     = rev_j;
        cmd_o.cap_a = 1'b1;
        state_d     = ST_REV_B;
      end
      ST_REV_B: begin
        cmd_o.cap_b = 1'b1;
        state_d     = ST_REV_W1;
      end
      ST_REV_W1: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_B;
        state_d    = ST_REV_W2;
      end
      ST_REV_W2: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_A;
        waddr_o    = rev_j;
        if (last_i) begin
          s_d         = LW'(1);
          j_d         = '0;
          g_d         = '0;
          cmd_o.w_one = 1'b1;
          state_d     = ST_BF_RD;
        end else begin
          i_d     = i_q + (AW+1)'(1);
          state_d = ST_REV;
        end
      end

      // Butterfly: fetch odd then even operand, multiply, write back
      ST_BF_RD: begin
        raddr_o = hi;
        state_d = ST_BF_RD2;
      end
      ST_BF_RD2: begin
        raddr_o     = lo;
        cmd_o.cap_b = 1'b1;
        state_d     = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd_o.cap_a     = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mop       = MOP_WV;
        state_d         = ST_BF_WAIT;
      end
      ST_BF_WAIT: begin
        if (status_i.mul_done) state_d = ST_BF_W1;
      end
      ST_BF_W1: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_SUM;
        waddr_o    = lo;
        state_d    = ST_BF_W2;
      end
      ST_BF_W2: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_DIFF;
        waddr_o    = hi;
        // groups inner, twiddle index outer
        if (!last_grp) begin
          g_d     = AW'((AW+1)'(g_q) + len);
          state_d = ST_BF_RD;
        end else begin
          g_d = '0;
          if (!last_j) begin
            j_d     = j_q + AW'(1);
            state_d = ST_TW_MUL;
          end else if (s_q != lg_q) begin
            s_d         = s_q + LW'(1);
            j_d         = '0;
            cmd_o.w_one = 1'b1;
            state_d     = ST_BF_RD;
          end else if (inv_q) begin
            i_d     = '0;
            state_d = ST_SC_RD;
          end else begin
            rd_idx_d = '0;
            state_d  = ST_READ;
          end
        end
      end

      // Advance twiddle by the stage step
      ST_TW_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mop       = MOP_WSTEP;
        state_d         = ST_TW_WAIT;
      end
      ST_TW_WAIT: begin
        cmd_o.mop = MOP_WSTEP;
        if (status_i.mul_done) begin
          cmd_o.w_load = 1'b1;
          state_d      = ST_BF_RD;
        end
      end

      // Inverse scaling by 1/N
      ST_SC_RD: begin
        state_d = ST_SC_CAP;
      end
      ST_SC_CAP: begin
        cmd_o.cap_b = 1'b1;
        state_d     = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mop       = MOP_SCALE;
        state_d         = ST_SC_WAIT;
      end
      ST_SC_WAIT: begin
        if (status_i.mul_done) state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_MUL;
        if (last_i) begin
          rd_idx_d = '0;
          state_d  = ST_READ;
        end else begin
          i_d     = i_q + (AW+1)'(1);
          state_d = ST_SC_RD;
        end
      end

      // Read-out in natural order; load requests are dropped
      ST_READ: begin
        raddr_o    = rd_idx_q;
        in_ready_o = !status_i.out_busy;
        if (in_valid_i && !status_i.out_busy && (in_req_i.cmd == CMD_READ)) begin
          state_d = ST_RD_OUT;
        end
      end
      ST_RD_OUT: begin
        raddr_o        = rd_idx_q;
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = (rd_idx_q == last_idx);
        if (rd_idx_q == last_idx) begin
          rd_idx_d = '0;
          state_d  = ST_LOAD;
        end else begin
          rd_idx_d = rd_idx_q + AW'(1);
          state_d  = ST_READ;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_len_q  <= LOG_LENGTH_RST;
      inv_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LOG_LENGTH)   log_len_q  <= cfg_data_i;
      if (cfg_idx_i == CFG_INVERSE_MODE) inv_mode_q <= cfg_data_i[0];
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_idx_q <= '0;
      rd_idx_q   <= '0;
      lg_q       <= LW'(LOG_MAX);
      inv_q      <= 1'b0;
      i_q        <= '0;
      s_q        <= LW'(1);
      j_q        <= '0;
      g_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
      rd_idx_q   <= rd_idx_d;
      lg_q       <= lg_d;
      inv_q      <= inv_d;
      i_q        <= i_d;
      s_q        <= s_d;
      j_q        <= j_d;
      g_q        <= g_d;
    end
  end

endmodule

/* hdl/number_theoretic_transform.sv */
// ----------------------------------------------------------------------------
// number_theoretic_transform
// Radix-2 NTT mod 998244353 over 2^L points with load, transform and read-out.
// ----------------------------------------------------------------------------
// Load requests are accepted back to back. The final load starts the transform:
// zero fill of the unloaded positions, bit reversal, N/2*L butterflies (each
// reads its operands from the buffer and waits for the multiplier) with a
// twiddle update between twiddle indices, and a scaling pass in inverse. Read
// requests are taken one at a time and wait while the result register stalls.
// Reset clears control and configuration; buffer contents are not cleared,
// unloaded entries are zeroed.
module number_theoretic_transform #(
  parameter int LOG_MAX = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ntt_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ntt_pkg::out_rsp_t              out_rsp_o
);
  import ntt_pkg::*;

  dp_cmd_t            dp_cmd;
  dp_status_t         dp_status;
  logic [LOG_MAX-1:0] raddr, waddr;

  ntt_ctrl #(.LOG_MAX(LOG_MAX)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .cmd_o      (dp_cmd),
    .raddr_o    (raddr),
    .waddr_o    (waddr),
    .status_i   (dp_status)
  );

  ntt_datapath #(.LOG_MAX(LOG_MAX)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .raddr_i     (raddr),
    .waddr_i     (waddr),
    .load_val_i  (in_req_i.coeff_in),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A new result appears only after an accepted read request, via ST_RD_OUT and the result register
  a_result_follows_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_req_i.cmd, 2))
    else $error("result without a read request");

  // Multiplier results only come back for issued operations
  a_mul_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.mul_done |-> $past(dp_cmd.mul_start, MUL_LAT))
    else $error("multiplier result without a matching start");

endmodule

/* test/ntt_checker.sv */
// ----------------------------------------------------------------------------
// ntt_checker
// Watches the request, result and configuration ports of the NTT block,
// keeps its own model of the buffer and transform, and compares each result
// with the oldest predicted value.
// ----------------------------------------------------------------------------
module ntt_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  ntt_pkg::in_req_t               in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  ntt_pkg::out_rsp_t              out_rsp_i,
  output int                             pending_o,
  output int                             rsp_count_o,
  output int                             errors_o
);
  import ntt_pkg::*;

  localparam int MAX_LOG = 10;
  localparam int DEPTH   = 1 << MAX_LOG;

  // Model state
  logic [29:0] coeff_mem [DEPTH];
  int          load_pos;
  int          read_pos;
  logic        reading;
  int          frame_log;
  logic [3:0]  log_reg;
  logic        inv_reg;
  out_rsp_t    expected_q [$];

  function automatic logic [29:0] mul_p(input logic [29:0] a, input logic [29:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return 30'(prod % 64'(MOD_P));
  endfunction

  function automatic logic [29:0] pow_p(input logic [29:0] base, input logic [31:0] ex);
    logic [29:0] acc;
    acc = 30'd1;
    while (ex != 0) begin
      if (ex[0]) acc = mul_p(acc, base);
      base = mul_p(base, base);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic int clamp_log(input logic [3:0] lg);
    if (lg < 1) return 1;
    if (lg > MAX_LOG) return MAX_LOG;
    return int'(lg);
  endfunction

  // In-place bit-reversed iterative transform over the model buffer
  task automatic transform(input int lg, input logic inv);
    int          n;
    int          rev;
    int          half;
    logic [29:0] root;
    logic [29:0] stride;
    logic [29:0] w;
    logic [29:0] u;
    logic [29:0] t;
    logic [29:0] tmp;
    logic [30:0] sum;
    logic [29:0] scale;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int b = 0; b < lg; b++) rev = (rev << 1) | ((i >> b) & 1);
      if (i < rev) begin
        tmp = coeff_mem[i];
        coeff_mem[i] = coeff_mem[rev];
        coeff_mem[rev] = tmp;
      end
    end
    root = pow_p(GEN_G, (32'(MOD_P) - 1) / n);
    if (inv) root = pow_p(root, n - 1);
    for (int len = 2; len <= n; len = len << 1) begin
      half = len >> 1;
      stride = pow_p(root, n / len);
      for (int s = 0; s < n; s += len) begin
        w = 30'd1;
        for (int j = 0; j < half; j++) begin
          u = coeff_mem[s+j];
          t = mul_p(w, coeff_mem[s+j+half]);
          coeff_mem[s+j+half] = (u >= t) ? u - t : 30'(31'(u) + 31'(MOD_P) - 31'(t));
          sum = 31'(u) + 31'(t);
          if (sum >= 31'(MOD_P)) sum = sum - 31'(MOD_P);
          coeff_mem[s+j] = sum[29:0];
          w = mul_p(w, stride);
        end
      end
    end
    if (inv) begin
      scale = pow_p(30'(n), 32'(MOD_P) - 2);
      for (int i = 0; i < n; i++) coeff_mem[i] = mul_p(coeff_mem[i], scale);
    end
  endtask

  // Advance the model by one accepted request
  task automatic apply_request(input in_req_t req);
    int          lg;
    int          n;
    logic [29:0] val;
    out_rsp_t    rsp;
    if (!reading) begin
      if (req.cmd == CMD_LOAD) begin
        lg = clamp_log(log_reg);
        n = 1 << lg;
        val = (req.coeff_in >= MOD_P) ? req.coeff_in - MOD_P : req.coeff_in;
        if (load_pos < n) begin
          coeff_mem[load_pos] = val;
          load_pos++;
        end
        if (req.final_load) begin
          for (int i = load_pos; i < n; i++) coeff_mem[i] = '0;
          transform(lg, inv_reg);
          frame_log = lg;
          load_pos = 0;
          read_pos = 0;
          reading = 1'b1;
        end
      end
    end else if (req.cmd == CMD_READ) begin
      n = 1 << frame_log;
      rsp.coeff_out = coeff_mem[read_pos];
      rsp.final_out = (read_pos == n - 1);
      expected_q.push_back(rsp);
      if (rsp.final_out) begin
        read_pos = 0;
        reading = 1'b0;
      end else begin
        read_pos++;
      end
    end
  endtask

  task automatic report(input string what);
    $display("ntt_checker: mismatch on %s", what);
    errors_o++;
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos = 0;
      read_pos = 0;
      reading = 1'b0;
      log_reg = LOG_LENGTH_RST;
      inv_reg = 1'b0;
      frame_log = MAX_LOG;
      expected_q.delete();
    end else begin
      out_rsp_t exp_rsp;
      // Result side first: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        rsp_count_o++;
        if (expected_q.size() == 0) begin
          report("unexpected result");
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_rsp_i.coeff_out !== exp_rsp.coeff_out) report("coeff_out");
          if (out_rsp_i.final_out !== exp_rsp.final_out) report("final_out");
        end
      end
      if (in_valid_i && in_ready_i) apply_request(in_req_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LOG_LENGTH) log_reg = cfg_data_i;
        else if (cfg_idx_i == CFG_INVERSE_MODE) inv_reg = cfg_data_i[0];
      end
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives loads, reads and configuration into the NTT block with random
// gaps and stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import ntt_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_req;
  logic                  out_valid;
  logic                  out_ready;
  out_rsp_t              out_rsp;
  int                    pending;
  int                    rsp_count;
  int                    errors;
  int                    req_count;
  logic                  calm;
  logic                  held;

  number_theoretic_transform dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  ntt_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_i  (out_rsp),
    .pending_o  (pending),
    .rsp_count_o(rsp_count),
    .errors_o   (errors)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Hard stop for a hung run
  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

  // Send one request, with an occasional idle burst in front
  task automatic send(input logic cmd, input logic [29:0] val, input logic fin);
    if (!calm && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_req   <= '{cmd: cmd, coeff_in: val, final_load: fin};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    req_count++;
  endtask

  // Quiet the request side and wait until every result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [29:0] rand_coeff();
    if ($urandom_range(0, 7) == 0) return 30'($urandom);
    return 30'($urandom_range(0, 998244352));
  endfunction

  // One frame: loads (with stray reads), then the read-out (with stray loads)
  task automatic run_frame(input int lg, input int loads, input logic noisy);
    int n;
    n = 1 << lg;
    for (int i = 0; i < loads; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send(CMD_READ, 30'($urandom), 1'b0);
      send(CMD_LOAD, rand_coeff(), i == loads - 1);
    end
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send(CMD_LOAD, 30'($urandom), 1'($urandom));
      send(CMD_READ, 30'($urandom), 1'($urandom));
    end
  endtask

  // Receiver: random stalls, one long hold-off, none near the end
  initial begin
    out_ready = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && rsp_count >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int lg;
    int loads;
    logic [3:0] lg_reg;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    req_count = 0;
    calm      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: smallest length, field extremes, stray read while loading
    write_reg(CFG_LOG_LENGTH, 4'd1);
    write_reg(CFG_INVERSE_MODE, 4'd0);
    send(CMD_READ, 30'h3FFF_FFFF, 1'b1);
    send(CMD_LOAD, 30'h3FFF_FFFF, 1'b0);
    send(CMD_LOAD, MOD_P, 1'b0);
    send(CMD_LOAD, MOD_P - 30'd1, 1'b0);
    send(CMD_LOAD, 30'd0, 1'b1);
    send(CMD_LOAD, 30'd5, 1'b1);
    send(CMD_READ, 30'd0, 1'b0);
    send(CMD_READ, 30'd0, 1'b0);
    drain();
    // Length zero acts as one; inverse mode; short load
    write_reg(CFG_LOG_LENGTH, 4'd0);
    write_reg(CFG_INVERSE_MODE, 4'd1);
    run_frame(1, 1, 1'b0);
    drain();
    // Length above the maximum acts as the largest, forward, extreme residues
    write_reg(CFG_INVERSE_MODE, 4'd0);
    write_reg(CFG_LOG_LENGTH, 4'd15);
    send(CMD_LOAD, MOD_P - 30'd1, 1'b0);
    send(CMD_LOAD, 30'd0, 1'b1);
    for (int i = 0; i < 1024; i++) send(CMD_READ, 30'd0, 1'b0);
    drain();

    // Random frames at small lengths
    while (req_count < 1800) begin
      if (req_count >= 1600) calm = 1'b1;
      lg = int'($urandom_range(1, 5));
      lg_reg = 4'(lg);
      if (lg == 1 && $urandom_range(0, 1) == 0) lg_reg = 4'd0;
      write_reg(CFG_LOG_LENGTH, lg_reg);
      write_reg(CFG_INVERSE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0:       loads = int'($urandom_range(1, 1 << lg));
        1:       loads = (1 << lg) + int'($urandom_range(1, 4));
        default: loads = 1 << lg;
      endcase
      run_frame(lg, loads, 1'b1);
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
